// ===== src/yvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUYV to NV12 converter package
// Shared sizes, register codes and the structs passed between the blocks.
// ----------------------------------------------------------------------------
package yvc_pkg;

  localparam int MAX_LINE_PIXELS = 4096;
  localparam int MAX_LINES       = 4096;
  localparam int STORE_DEPTH     = MAX_LINE_PIXELS / 2;
  localparam int STORE_AW        = $clog2(STORE_DEPTH);
  localparam int COL_LIMIT       = 4096;
  localparam int REG_W           = 13;
  localparam int COL_W           = 12;
  localparam int ADDR_W          = 25;
  localparam int REG_IDX_W       = 3;

  localparam logic [REG_IDX_W-1:0] REG_ACTIVE_WIDTH       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE_HEIGHT      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_LINE_GROUPS = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DEST_LINE_STRIDE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DEST_PLANE_ROWS    = 3'd4;

  typedef struct packed {
    logic [REG_W-1:0]  line_len;
    logic [COL_W-1:0]  groups;
    logic [REG_W-1:0]  height;
    logic [REG_W-1:0]  stride;
    logic [ADDR_W-1:0] plane_base;
  } cfg_t;

  typedef struct packed {
    logic              odd;
    logic              last_frame;
    logic [ADDR_W-1:0] luma_addr;
    logic [ADDR_W-1:0] chroma_off;
    logic [7:0]        y0;
    logic [7:0]        y1;
    logic [7:0]        u;
    logic [7:0]        v;
  } item_t;

endpackage

// ===== src/yvc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB register file with the clamped line and frame figures derived from it.
// ----------------------------------------------------------------------------
module yvc_cfg_regs (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [4:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output yvc_pkg::cfg_t            cfg
);

  logic [yvc_pkg::REG_W-1:0]     active_width;
  logic [yvc_pkg::REG_W-1:0]     active_height;
  logic [yvc_pkg::REG_W-1:0]     source_line_groups;
  logic [yvc_pkg::REG_W-1:0]     dest_line_stride;
  logic [yvc_pkg::REG_W-1:0]     dest_plane_rows;
  logic [yvc_pkg::REG_IDX_W-1:0] reg_index;
  logic                          wr;
  logic [yvc_pkg::REG_W-1:0]     line_len_next;
  logic [yvc_pkg::REG_W:0]       width_plus_one;
  logic [yvc_pkg::REG_W-1:0]     half_width;
  logic [yvc_pkg::REG_W-1:0]     groups_next;
  logic [yvc_pkg::REG_W-1:0]     height_next;
  logic [yvc_pkg::ADDR_W-1:0]    plane_base;

  assign reg_index = paddr[4:2];
  assign wr        = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width       <= yvc_pkg::REG_W'(640);
      active_height      <= yvc_pkg::REG_W'(480);
      source_line_groups <= yvc_pkg::REG_W'(320);
      dest_line_stride   <= yvc_pkg::REG_W'(640);
      dest_plane_rows    <= yvc_pkg::REG_W'(480);
    end else if (wr) begin
      case (reg_index)
        yvc_pkg::REG_ACTIVE_WIDTH:       active_width       <= pwdata[yvc_pkg::REG_W-1:0];
        yvc_pkg::REG_ACTIVE_HEIGHT:      active_height      <= pwdata[yvc_pkg::REG_W-1:0];
        yvc_pkg::REG_SOURCE_LINE_GROUPS: source_line_groups <= pwdata[yvc_pkg::REG_W-1:0];
        yvc_pkg::REG_DEST_LINE_STRIDE:   dest_line_stride   <= pwdata[yvc_pkg::REG_W-1:0];
        yvc_pkg::REG_DEST_PLANE_ROWS:    dest_plane_rows    <= pwdata[yvc_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      yvc_pkg::REG_ACTIVE_WIDTH:       prdata = 32'(active_width);
      yvc_pkg::REG_ACTIVE_HEIGHT:      prdata = 32'(active_height);
      yvc_pkg::REG_SOURCE_LINE_GROUPS: prdata = 32'(source_line_groups);
      yvc_pkg::REG_DEST_LINE_STRIDE:   prdata = 32'(dest_line_stride);
      yvc_pkg::REG_DEST_PLANE_ROWS:    prdata = 32'(dest_plane_rows);
      default:                         prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (source_line_groups == '0) begin
      line_len_next = yvc_pkg::REG_W'(1);
    end else if (source_line_groups > yvc_pkg::REG_W'(yvc_pkg::COL_LIMIT)) begin
      line_len_next = yvc_pkg::REG_W'(yvc_pkg::COL_LIMIT);
    end else begin
      line_len_next = source_line_groups;
    end
    width_plus_one = {1'b0, active_width} + (yvc_pkg::REG_W+1)'(1);
    half_width     = width_plus_one[yvc_pkg::REG_W:1];
    if (half_width > yvc_pkg::REG_W'(yvc_pkg::STORE_DEPTH)) begin
      groups_next = yvc_pkg::REG_W'(yvc_pkg::STORE_DEPTH);
    end else begin
      groups_next = half_width;
    end
    if (groups_next > line_len_next) begin
      groups_next = line_len_next;
    end
    if (active_height > yvc_pkg::REG_W'(yvc_pkg::MAX_LINES)) begin
      height_next = yvc_pkg::REG_W'(yvc_pkg::MAX_LINES);
    end else begin
      height_next = active_height;
    end
  end

  // The chroma plane base is registered and settles in the cycle after a register write, before any
  // chroma write of a group transferred after that write can reach it.
  always_ff @(posedge clk) begin
    plane_base <= yvc_pkg::ADDR_W'(dest_plane_rows * dest_line_stride);
  end

  always_comb begin
    cfg.line_len   = line_len_next;
    cfg.groups     = groups_next[yvc_pkg::COL_W-1:0];
    cfg.height     = height_next;
    cfg.stride     = dest_line_stride;
    cfg.plane_base = plane_base;
  end

endmodule

// ===== src/yvc_line_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chroma line store
// One-write one-read synchronous memory holding the U and V of an even row.
// ----------------------------------------------------------------------------
module yvc_line_store (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [yvc_pkg::STORE_AW-1:0]  wr_addr,
  input  logic [15:0]                   wr_data,
  input  logic                          rd_en,
  input  logic [yvc_pkg::STORE_AW-1:0]  rd_addr,
  output logic [15:0]                   rd_data
);

  logic [15:0] mem [yvc_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/yvc_raster_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster position tracker
// Follows column, row and row base addresses, and issues the line store access.
// ----------------------------------------------------------------------------
module yvc_raster_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  yvc_pkg::cfg_t                 cfg,
  input  logic                          accept,
  input  logic                          frame_start,
  input  logic [31:0]                   pixels,
  output logic                          emit,
  output yvc_pkg::item_t                item,
  output logic                          store_wr_en,
  output logic                          store_rd_en,
  output logic [yvc_pkg::STORE_AW-1:0]  store_addr,
  output logic [15:0]                   store_wr_data
);

  logic [yvc_pkg::COL_W-1:0]  column_group, column_group_next;
  logic [yvc_pkg::COL_W-1:0]  row_index, row_index_next;
  logic [yvc_pkg::ADDR_W-1:0] luma_row_base, luma_row_base_next;
  logic [yvc_pkg::ADDR_W-1:0] chroma_row_base, chroma_row_base_next;
  logic                       frame_over, frame_over_next;
  logic [yvc_pkg::COL_W-1:0]  g;
  logic [yvc_pkg::COL_W-1:0]  row;
  logic [yvc_pkg::ADDR_W-1:0] lbase;
  logic [yvc_pkg::ADDR_W-1:0] cbase;
  logic                       over;
  logic [yvc_pkg::REG_W-1:0]  col_inc;
  logic [yvc_pkg::REG_W-1:0]  row_inc;
  logic [yvc_pkg::ADDR_W-1:0] col_offset;

  always_comb begin
    g     = frame_start ? '0 : column_group;
    row   = frame_start ? '0 : row_index;
    lbase = frame_start ? '0 : luma_row_base;
    cbase = frame_start ? '0 : chroma_row_base;
    over  = frame_start ? 1'b0 : frame_over;

    col_inc    = {1'b0, g} + yvc_pkg::REG_W'(1);
    row_inc    = {1'b0, row} + yvc_pkg::REG_W'(1);
    col_offset = yvc_pkg::ADDR_W'({g, 1'b0});

    emit = !over && (cfg.height != '0) && (g < cfg.groups) && ({1'b0, row} < cfg.height);

    item.odd        = row[0];
    item.last_frame = (row_inc == cfg.height) &&
                      (g == cfg.groups - yvc_pkg::COL_W'(1));
    item.luma_addr  = lbase + col_offset;
    item.chroma_off = cbase + col_offset;
    item.y0         = pixels[7:0];
    item.u          = pixels[15:8];
    item.y1         = pixels[23:16];
    item.v          = pixels[31:24];

    store_addr    = g[yvc_pkg::STORE_AW-1:0];
    store_wr_data = {pixels[15:8], pixels[31:24]};
    store_wr_en   = accept && emit && !row[0];
    store_rd_en   = accept && emit && row[0];

    column_group_next    = g;
    row_index_next       = row;
    luma_row_base_next   = lbase;
    chroma_row_base_next = cbase;
    frame_over_next      = over;
    if (!over) begin
      if (cfg.height == '0) begin
        frame_over_next = 1'b1;
      end else if (col_inc >= cfg.line_len) begin
        column_group_next  = '0;
        luma_row_base_next = lbase + yvc_pkg::ADDR_W'(cfg.stride);
        if (row[0]) begin
          chroma_row_base_next = cbase + yvc_pkg::ADDR_W'(cfg.stride);
        end
        if (row_inc >= cfg.height) begin
          frame_over_next = 1'b1;
        end else begin
          row_index_next = row_inc[yvc_pkg::COL_W-1:0];
        end
      end else begin
        column_group_next = col_inc[yvc_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_group    <= '0;
      row_index       <= '0;
      luma_row_base   <= '0;
      chroma_row_base <= '0;
      frame_over      <= 1'b0;
    end else if (accept) begin
      column_group    <= column_group_next;
      row_index       <= row_index_next;
      luma_row_base   <= luma_row_base_next;
      chroma_row_base <= chroma_row_base_next;
      frame_over      <= frame_over_next;
    end
  end

endmodule

// ===== src/yvc_write_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Write sequencer
// Holds one group, averages its chroma with the line store data and issues
// the luma and chroma writes through an output register.
// ----------------------------------------------------------------------------
module yvc_write_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  yvc_pkg::item_t            item,
  input  logic [15:0]               store_data,
  input  logic [yvc_pkg::ADDR_W-1:0] plane_base,
  output logic                      free,
  output logic                      o_valid,
  input  logic                      o_ready,
  output logic                      o_plane,
  output logic [yvc_pkg::ADDR_W-1:0] o_addr,
  output logic [7:0]                o_b0,
  output logic [7:0]                o_b1,
  output logic                      o_last,
  output logic                      o_done
);

  logic           s1_valid;
  logic           s1_phase;
  yvc_pkg::item_t s1_item;
  logic           move;
  logic           final_move;
  logic [8:0]     sum_u;
  logic [8:0]     sum_v;

  assign move       = s1_valid && (!o_valid || o_ready);
  assign final_move = move && (s1_phase || !s1_item.odd);
  assign free       = !s1_valid || final_move;
  assign sum_u      = {1'b0, store_data[15:8]} + {1'b0, s1_item.u};
  assign sum_v      = {1'b0, store_data[7:0]} + {1'b0, s1_item.v};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_phase <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
        s1_phase <= 1'b0;
      end else if (final_move) begin
        s1_valid <= 1'b0;
        s1_phase <= 1'b0;
      end else if (move) begin
        s1_phase <= 1'b1;
      end
      if (move) begin
        o_valid <= 1'b1;
      end else if (o_ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item <= item;
    end
    if (move) begin
      if (s1_phase) begin
        o_plane <= 1'b1;
        o_addr  <= plane_base + s1_item.chroma_off;
        o_b0    <= sum_u[8:1];
        o_b1    <= sum_v[8:1];
        o_last  <= 1'b1;
        o_done  <= s1_item.last_frame;
      end else begin
        o_plane <= 1'b0;
        o_addr  <= s1_item.luma_addr;
        o_b0    <= s1_item.y0;
        o_b1    <= s1_item.y1;
        o_last  <= !s1_item.odd;
        o_done  <= !s1_item.odd && s1_item.last_frame;
      end
    end
  end

`ifndef SYNTHESIS
  a_phase_odd: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_phase |-> s1_item.odd)
    else $error("Second write pending for an even-row group.");
  a_chroma_follows: assert property (@(posedge clk) disable iff (rst)
    move && s1_phase |=> o_valid && o_plane)
    else $error("Chroma write did not reach the output register.");
  a_chroma_last: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_plane |-> o_last)
    else $error("Chroma write not marked as last of its group.");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_done |-> o_last)
    else $error("End of frame marked on a write that is not last of its group.");
`endif

endmodule

// ===== src/yuyv_to_nv12_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUYV to NV12 converter
// Turns a raster stream of YUYV 4:2:2 groups into NV12 luma and chroma writes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         one YUYV group (two pixels), tuser marks frame start
//  m_axis    out        one two-byte write to the luma or chroma plane
//  apb       in         five line and frame geometry registers
//
// A group on an even row leaves one luma write; a group on an odd row leaves
// a luma and a chroma write through the single output port.
// The line store is touched at most once per group, a write on even rows and
// a read on odd rows; the first write of a group passes through the held group
// and then the output register. Reset clears the raster position; the line store is not cleared.
// An output register and a held group let one transfer in while a write waits.
// ----------------------------------------------------------------------------
module yuyv_to_nv12_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // luma_even, chroma_blue, luma_odd, chroma_red
  input  logic        s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // write_address, first_byte, second_byte, zero fill
  output logic [1:0]  m_axis_tuser,   // plane_select, frame_done
  output logic        m_axis_tlast,   // last_of_group
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  yvc_pkg::cfg_t                 cfg;
  yvc_pkg::item_t                item;
  logic                          accept;
  logic                          emit;
  logic                          free;
  logic                          store_wr_en;
  logic                          store_rd_en;
  logic [yvc_pkg::STORE_AW-1:0]  store_addr;
  logic [15:0]                   store_wr_data;
  logic [15:0]                   store_rd_data;
  logic                          o_plane;
  logic [yvc_pkg::ADDR_W-1:0]    o_addr;
  logic [7:0]                    o_b0;
  logic [7:0]                    o_b1;
  logic                          o_done;

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && free;
  assign m_axis_tdata  = {7'd0, o_b1, o_b0, o_addr};
  assign m_axis_tuser  = {o_done, o_plane};

  yvc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  yvc_raster_ctrl u_raster (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .accept        (accept),
    .frame_start   (s_axis_tuser),
    .pixels        (s_axis_tdata),
    .emit          (emit),
    .item          (item),
    .store_wr_en   (store_wr_en),
    .store_rd_en   (store_rd_en),
    .store_addr    (store_addr),
    .store_wr_data (store_wr_data)
  );

  yvc_line_store u_store (
    .clk     (clk),
    .wr_en   (store_wr_en),
    .wr_addr (store_addr),
    .wr_data (store_wr_data),
    .rd_en   (store_rd_en),
    .rd_addr (store_addr),
    .rd_data (store_rd_data)
  );

  yvc_write_queue u_writes (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && emit),
    .item       (item),
    .store_data (store_rd_data),
    .plane_base (cfg.plane_base),
    .free       (free),
    .o_valid    (m_axis_tvalid),
    .o_ready    (m_axis_tready),
    .o_plane    (o_plane),
    .o_addr     (o_addr),
    .o_b0       (o_b0),
    .o_b1       (o_b1),
    .o_last     (m_axis_tlast),
    .o_done     (o_done)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the YUYV to NV12 converter
// Drives YUYV groups in raster order over the input stream and geometry over
// APB. An internal copy of the raster position, row bases and chroma line
// buffer predicts every luma and chroma plane write, and each write on the
// output stream is compared field by field with the oldest prediction. Both
// stream sides idle in short random bursts, the receiver also holds off for
// a long stretch, and the geometry is changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import yvc_pkg::*;

  typedef struct {
    bit              plane;
    bit [ADDR_W-1:0] addr;
    bit [7:0]        b0;
    bit [7:0]        b1;
    bit              last;
    bit              done;
  } nv12_write_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // luma_even, chroma_blue, luma_odd, chroma_red
  logic        s_axis_tuser;   // frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // write_address, first_byte, second_byte, zero fill
  logic [1:0]  m_axis_tuser;   // plane_select, frame_done
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  yuyv_to_nv12_converter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  bit [REG_W-1:0]  geo_width      = 13'd640;
  bit [REG_W-1:0]  geo_height     = 13'd480;
  bit [REG_W-1:0]  geo_src_groups = 13'd320;
  bit [REG_W-1:0]  geo_stride     = 13'd640;
  bit [REG_W-1:0]  geo_rows       = 13'd480;
  int unsigned     col_pos;
  int unsigned     row_pos;
  bit [ADDR_W-1:0] luma_base;
  bit [ADDR_W-1:0] chroma_base;
  bit              frame_closed;
  bit [15:0]       uv_line [STORE_DEPTH];
  nv12_write_t     pending_writes [$];

  int errors       = 0;
  int groups_fed   = 0;
  int luma_seen    = 0;
  int chroma_seen  = 0;
  int geometries   = 0;
  bit idling       = 1'b1;
  int sink_hold    = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("yuyv_to_nv12_converter verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
  endtask

  function automatic int unsigned line_length();
    int unsigned len;
    len = (geo_src_groups == 0) ? 1 : geo_src_groups;
    if (len > COL_LIMIT) len = COL_LIMIT;
    return len;
  endfunction

  function automatic int unsigned active_groups();
    int unsigned grp;
    grp = (int'(geo_width) + 1) >> 1;
    if (grp > STORE_DEPTH) grp = STORE_DEPTH;
    if (grp > line_length()) grp = line_length();
    return grp;
  endfunction

  function automatic int unsigned frame_height();
    return (geo_height > MAX_LINES) ? MAX_LINES : geo_height;
  endfunction

  function automatic void convert_group(input bit fs, input bit [31:0] d);
    bit [7:0]        y0;
    bit [7:0]        u;
    bit [7:0]        y1;
    bit [7:0]        v;
    int unsigned     len;
    int unsigned     grp;
    int unsigned     hgt;
    int unsigned     g;
    bit              odd;
    bit              last_frame;
    bit [15:0]       stored;
    bit [ADDR_W-1:0] plane_base;
    nv12_write_t     w;
    y0 = d[7:0];
    u  = d[15:8];
    y1 = d[23:16];
    v  = d[31:24];
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
      luma_base = '0;
      chroma_base = '0;
      frame_closed = 1'b0;
    end
    if (frame_closed) return;
    groups_fed++;
    len = line_length();
    grp = active_groups();
    hgt = frame_height();
    if (hgt == 0) begin
      frame_closed = 1'b1;
      return;
    end
    g = col_pos;
    if (g < grp && row_pos < hgt) begin
      odd = row_pos[0];
      last_frame = (row_pos == hgt - 1) && (g == grp - 1);
      w.plane = 1'b0;
      w.addr  = ADDR_W'(luma_base + 2 * g);
      w.b0    = y0;
      w.b1    = y1;
      w.last  = !odd;
      w.done  = !odd && last_frame;
      pending_writes.push_back(w);
      if (odd) begin
        stored = uv_line[g % STORE_DEPTH];
        plane_base = geo_rows * geo_stride;
        w.plane = 1'b1;
        w.addr  = ADDR_W'(plane_base + chroma_base + 2 * g);
        w.b0    = 8'((int'(stored[15:8]) + int'(u)) >> 1);
        w.b1    = 8'((int'(stored[7:0]) + int'(v)) >> 1);
        w.last  = 1'b1;
        w.done  = last_frame;
        pending_writes.push_back(w);
      end else begin
        uv_line[g % STORE_DEPTH] = {u, v};
      end
    end
    col_pos = g + 1;
    if (col_pos >= len) begin
      col_pos = 0;
      if (row_pos[0]) chroma_base = chroma_base + geo_stride;
      luma_base = luma_base + geo_stride;
      if (row_pos + 1 >= hgt) frame_closed = 1'b1;
      else row_pos++;
    end
  endfunction

  always @(posedge clk) begin : check_writes
    nv12_write_t exp_w;
    bit [ADDR_W-1:0] got_addr;
    bit [7:0] got_b0;
    bit [7:0] got_b1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_addr = m_axis_tdata[24:0];
      got_b0 = m_axis_tdata[32:25];
      got_b1 = m_axis_tdata[40:33];
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("write to 0x%07h with nothing expected", got_addr));
      end else begin
        exp_w = pending_writes.pop_front();
        if (exp_w.plane) chroma_seen++;
        else luma_seen++;
        if (m_axis_tuser[0] !== exp_w.plane)
          report_mismatch($sformatf("plane_select %b, expected %b", m_axis_tuser[0],
                                    exp_w.plane));
        if (got_addr !== exp_w.addr)
          report_mismatch($sformatf("write_address 0x%07h, expected 0x%07h", got_addr,
                                    exp_w.addr));
        if (got_b0 !== exp_w.b0)
          report_mismatch($sformatf("first_byte 0x%02h, expected 0x%02h", got_b0, exp_w.b0));
        if (got_b1 !== exp_w.b1)
          report_mismatch($sformatf("second_byte 0x%02h, expected 0x%02h", got_b1, exp_w.b1));
        if (m_axis_tlast !== exp_w.last)
          report_mismatch($sformatf("last_of_group %b, expected %b", m_axis_tlast,
                                    exp_w.last));
        if (m_axis_tuser[1] !== exp_w.done)
          report_mismatch($sformatf("frame_done %b, expected %b", m_axis_tuser[1],
                                    exp_w.done));
      end
    end
  end

  initial begin : sink
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        m_axis_tready = 1'b0;
        sink_hold--;
      end else if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else if (idling && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        stall = $urandom_range(0, 3);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic send_group(input bit fs, input bit [31:0] d);
    int gap;
    gap = 0;
    if (idling && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = d;
    s_axis_tuser = fs;
    do @(posedge clk); while (!s_axis_tready);
    convert_group(fs, d);
    @(negedge clk);
  endtask

  task automatic send_frame(input int count, input bit noisy);
    bit fs;
    for (int i = 0; i < count; i++) begin
      fs = (i == 0) || (noisy && $urandom_range(0, 63) == 0);
      send_group(fs, $urandom);
    end
  endtask

  task automatic drain(input int settle);
    s_axis_tvalid = 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic apb_check(input bit [REG_IDX_W-1:0] idx, input bit [REG_W-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(value))
      report_mismatch($sformatf("register %0d reads 0x%08h, expected 0x%08h", idx, prdata,
                                32'(value)));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apb_write(input bit [REG_IDX_W-1:0] idx, input bit [REG_W-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ACTIVE_WIDTH:       geo_width = value;
      REG_ACTIVE_HEIGHT:      geo_height = value;
      REG_SOURCE_LINE_GROUPS: geo_src_groups = value;
      REG_DEST_LINE_STRIDE:   geo_stride = value;
      REG_DEST_PLANE_ROWS:    geo_rows = value;
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    apb_check(idx, value);
  endtask

  task automatic set_geometry(input int w, input int h, input int src, input int stride,
                              input int rows);
    drain(8);
    apb_write(REG_ACTIVE_WIDTH, REG_W'(w));
    apb_write(REG_ACTIVE_HEIGHT, REG_W'(h));
    apb_write(REG_SOURCE_LINE_GROUPS, REG_W'(src));
    apb_write(REG_DEST_LINE_STRIDE, REG_W'(stride));
    apb_write(REG_DEST_PLANE_ROWS, REG_W'(rows));
    geometries++;
  endtask

  task automatic test_register_access();
    apb_check(REG_ACTIVE_WIDTH, 13'd640);
    apb_check(REG_ACTIVE_HEIGHT, 13'd480);
    apb_check(REG_SOURCE_LINE_GROUPS, 13'd320);
    apb_check(REG_DEST_LINE_STRIDE, 13'd640);
    apb_check(REG_DEST_PLANE_ROWS, 13'd480);
  endtask

  task automatic test_pixel_extremes();
    set_geometry(4, 2, 2, 8, 2);
    send_group(1'b1, 32'h0000_0000);
    send_group(1'b0, 32'hFFFF_FFFF);
    send_group(1'b0, 32'h0000_0000);
    send_group(1'b0, 32'hFFFF_FFFF);
    send_group(1'b1, 32'h00FF_00FF);
    send_group(1'b0, 32'hFF00_FF00);
    send_group(1'b0, 32'hFF00_FF00);
    send_group(1'b0, 32'h00FF_00FF);
    // The frame is complete, so this group must be dropped.
    send_group(1'b0, 32'h5AA5_C33C);
    drain(8);
  endtask

  task automatic test_odd_geometry();
    set_geometry(3, 3, 3, 6, 4);
    send_frame(9, 1'b0);
    drain(8);
  endtask

  task automatic test_narrow_source();
    set_geometry(8, 2, 2, 10, 3);
    send_frame(3, 1'b0);
    send_frame(4, 1'b0);
    drain(8);
  endtask

  task automatic test_geometry_limits();
    set_geometry(4096, 4096, 4096, 4096, 4096);
    send_frame(4, 1'b0);
    set_geometry(2, 2, 1, 2, 2);
    send_frame(2, 1'b0);
    drain(8);
  endtask

  task automatic test_backpressure();
    set_geometry(16, 4, 8, 16, 4);
    sink_hold = 150;
    send_frame(32, 1'b0);
    send_frame(12, 1'b0);
    drain(0);
    for (int i = 0; i < 20; i++) send_group(1'b0, $urandom);
    drain(8);
  endtask

  task automatic test_random_frames(input int item_goal, input bit with_idling);
    int target;
    int w;
    int h;
    int total;
    int count;
    idling = with_idling;
    target = groups_fed + item_goal;
    while (groups_fed < target) begin
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(25, 300);
        h = 2;
      end else begin
        w = $urandom_range(2, 24);
        h = $urandom_range(2, 8);
      end
      set_geometry(w, h, $urandom_range(1, (w + 1) / 2 + 3),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4096)
                                              : $urandom_range(2, 64),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4096)
                                              : $urandom_range(2, 16));
      repeat ($urandom_range(1, 3)) begin
        total = line_length() * frame_height();
        if ($urandom_range(0, 5) == 0) count = $urandom_range(1, total);
        else count = total + $urandom_range(0, 2);
        send_frame(count, 1'b1);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_register_access();
    test_pixel_extremes();
    test_odd_geometry();
    test_narrow_source();
    test_geometry_limits();
    test_backpressure();
    test_random_frames(750, 1'b1);
    test_random_frames(150, 1'b0);

    s_axis_tvalid = 1'b0;
    for (int i = 0; i < 20000 && pending_writes.size() != 0; i++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (pending_writes.size() != 0)
      report_mismatch($sformatf("%0d writes never arrived", pending_writes.size()));

    $display("Fed %0d groups through %0d geometries, checked %0d luma and %0d chroma writes.",
             groups_fed, geometries, luma_seen, chroma_seen);
    $display("Included frame restarts, padded and odd-sized lines, and a long output stall.");
    if (errors == 0) begin
      $display("yuyv_to_nv12_converter verification clean");
    end else begin
      $display("yuyv_to_nv12_converter verification failed");
    end
    $finish;
  end

endmodule
